// ----- hdl/opwcs_pkg.sv -----
package opwcs_pkg;

  // Default column limit of the panel
  localparam int unsigned MaxColumnsDef = 128;

  // Bus control bytes and command codes
  localparam logic [7:0] CtrlCmd     = 8'h00;
  localparam logic [7:0] CtrlData    = 8'h40;
  localparam logic [7:0] CmdSetMode  = 8'h20;
  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam logic [7:0] ColLowMask  = 8'h0F;
  localparam logic [7:0] PageMask    = 8'h07;
  localparam logic [1:0] ModePage    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] PanelWidthRst = 8'd128;
  localparam logic [6:0] DevAddrRst    = 7'd60;

  // Job queue between front and back
  localparam int unsigned JobQDepth = 2;
  localparam int unsigned JobQPtrW  = $clog2(JobQDepth);
  localparam int unsigned JobQCntW  = $clog2(JobQDepth + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PANEL_WIDTH    = 1'b0,
    CFG_DEVICE_ADDRESS = 1'b1
  } cfg_idx_e;

  // Request operations
  typedef enum logic [0:0] {
    OP_DRAW     = 1'b0,
    OP_SET_MODE = 1'b1
  } op_e;

  // Bus writes a job can hold, in emission order
  typedef enum logic [2:0] {
    STEP_MODE_CMD = 3'd0,
    STEP_MODE_ARG = 3'd1,
    STEP_PAGE     = 3'd2,
    STEP_COL_LO   = 3'd3,
    STEP_COL_HI   = 3'd4,
    STEP_DATA     = 3'd5
  } step_e;

  localparam int unsigned NumSteps = 6;

  typedef struct packed {
    logic       operation;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixels;
    logic [1:0] mode;
  } req_t;

  typedef struct packed {
    logic [6:0] bus_address;
    logic [7:0] control_byte;
    logic [7:0] payload;
    logic       last;
  } rsp_t;

  // One classified request: which writes remain, and their arguments
  typedef struct packed {
    logic [NumSteps-1:0] steps;
    logic [1:0]          mode_arg;
    logic [2:0]          page;
    logic [6:0]          column;
    logic [7:0]          pixels;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } jobq_status_t;

endpackage

// ----- hdl/opwcs_front.sv -----
module opwcs_front #(
  parameter int unsigned MaxColumns = opwcs_pkg::MaxColumnsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  opwcs_pkg::req_t          req_i,
  input  logic [7:0]               panel_width_i,
  input  opwcs_pkg::jobq_status_t  jobq_status_i,
  output logic                     full_o,
  output logic                     job_push_o,
  output opwcs_pkg::job_t          job_o
);
  import opwcs_pkg::*;

  localparam logic [7:0] MaxCol = 8'(MaxColumns);

  logic [1:0] addr_mode_q, addr_mode_d;
  logic [2:0] cur_page_q, cur_page_d;
  logic [6:0] cur_column_q, cur_column_d;
  logic       accept;
  logic [7:0] width_cap;
  logic [7:0] col_inc;
  job_t       job;

  assign accept = push_i && !jobq_status_i.full;

  // Effective width and column advance after a draw
  assign width_cap = (panel_width_i > MaxCol) ? MaxCol : panel_width_i;
  assign col_inc   = {1'b0, req_i.column} + 8'd1;

  // Classify the request and work out the tracked state after it
  always_comb begin
    job          = '0;
    job.page     = req_i.page;
    job.column   = req_i.column;
    job.pixels   = req_i.pixels;
    addr_mode_d  = addr_mode_q;
    cur_page_d   = cur_page_q;
    cur_column_d = cur_column_q;
    if (req_i.operation == OP_SET_MODE) begin
      job.steps[STEP_MODE_CMD] = 1'b1;
      job.steps[STEP_MODE_ARG] = 1'b1;
      job.mode_arg             = req_i.mode;
      addr_mode_d              = req_i.mode;
    end else begin
      job.steps[STEP_MODE_CMD] = (addr_mode_q != ModePage);
      job.steps[STEP_MODE_ARG] = (addr_mode_q != ModePage);
      job.steps[STEP_PAGE]     = (cur_page_q != req_i.page);
      job.steps[STEP_COL_LO]   = (cur_column_q != req_i.column);
      job.steps[STEP_COL_HI]   = (cur_column_q != req_i.column);
      job.steps[STEP_DATA]     = 1'b1;
      job.mode_arg             = ModePage;
      addr_mode_d              = ModePage;
      cur_page_d               = req_i.page;
      if (col_inc >= width_cap || col_inc >= MaxCol) begin
        cur_column_d = '0;
      end else begin
        cur_column_d = col_inc[6:0];
      end
    end
  end

  // Tracked controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_mode_q  <= ModePage;
      cur_page_q   <= '0;
      cur_column_q <= '0;
    end else if (accept) begin
      addr_mode_q  <= addr_mode_d;
      cur_page_q   <= cur_page_d;
      cur_column_q <= cur_column_d;
    end
  end

  assign full_o     = jobq_status_i.full;
  assign job_push_o = accept;
  assign job_o      = job;

endmodule

// ----- hdl/opwcs_jobq.sv -----
module opwcs_jobq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  opwcs_pkg::job_t          job_i,
  input  logic                     pop_i,
  output opwcs_pkg::job_t          job_o,
  output opwcs_pkg::jobq_status_t  status_o
);
  import opwcs_pkg::*;

  job_t                mem_q [JobQDepth];
  logic [JobQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobQCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == JobQCntW'(JobQDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == JobQPtrW'(JobQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == JobQPtrW'(JobQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/opwcs_back.sv -----
module opwcs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  opwcs_pkg::job_t          job_i,
  input  opwcs_pkg::jobq_status_t  jobq_status_i,
  input  logic [6:0]               dev_addr_i,
  input  logic                     pop_i,
  output logic                     job_pop_o,
  output logic                     empty_o,
  output opwcs_pkg::rsp_t          rsp_o
);
  import opwcs_pkg::*;

  job_t                job_q;
  logic                job_valid_q;
  rsp_t                out_q;
  logic                out_valid_q;
  logic [NumSteps-1:0] step_oh;
  logic [NumSteps-1:0] steps_rest;
  step_e               cur_step;
  logic                advance;
  logic                job_done;
  logic                job_load;
  rsp_t                rsp;

  // Lowest pending write goes next
  assign step_oh    = job_q.steps & (~job_q.steps + 1'b1);
  assign steps_rest = job_q.steps & ~step_oh;

  always_comb begin
    cur_step = STEP_DATA;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (job_q.steps[i]) begin
        cur_step = step_e'(3'(i));
      end
    end
  end

  // Build the bus write for the current step
  always_comb begin
    rsp.bus_address  = dev_addr_i;
    rsp.control_byte = CtrlCmd;
    rsp.last         = (steps_rest == '0);
    case (cur_step)
      STEP_MODE_CMD: rsp.payload = CmdSetMode;
      STEP_MODE_ARG: rsp.payload = {6'd0, job_q.mode_arg};
      STEP_PAGE:     rsp.payload = CmdPageBase | ({5'd0, job_q.page} & PageMask);
      STEP_COL_LO:   rsp.payload = {1'b0, job_q.column} & ColLowMask;
      STEP_COL_HI:   rsp.payload = CmdColHigh | {5'd0, job_q.column[6:4]};
      STEP_DATA: begin
        rsp.control_byte = CtrlData;
        rsp.payload      = job_q.pixels;
      end
      default:       rsp.payload = job_q.pixels;
    endcase
  end

  assign advance   = job_valid_q && (!out_valid_q || pop_i);
  assign job_done  = advance && (steps_rest == '0);
  assign job_load  = !jobq_status_i.empty && (!job_valid_q || job_done);
  assign job_pop_o = job_load;

  // Current job, retired one write at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (job_load) begin
      job_valid_q <= 1'b1;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_q <= job_i;
    end else if (advance) begin
      job_q.steps <= steps_rest;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp;
    end
  end

  assign empty_o = !out_valid_q;
  assign rsp_o   = out_q;

`ifndef SYNTHESIS
  // A held job always has a write left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.steps != '0))
    else $error("active job with no pending write");

  // Every job ends in a data write or a mode argument
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.steps[STEP_DATA] || job_q.steps[STEP_MODE_ARG]))
    else $error("job has no final write");

  // A waiting result is not dropped while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost or changed");
`endif

endmodule

// ----- hdl/oled_page_write_command_sequencer_unit.sv -----
// OLED page write command sequencer.
// Input channel: a request (draw one column byte, or set the addressing mode)
// is taken at a clock edge with push high and full low.
// Output channel: each result is one two-byte bus write (address, control
// byte, payload, last flag); it sits on rsp_o while empty is low and leaves at
// an edge with pop high. last marks the final write of a request.
// Configuration: cfg_we_i writes panel_width (index 0) or device_address
// (index 1) at the clock edge; write only while the block is idle.
// The first write of a request passes the job queue, the job register and
// the output register. Throughput: one bus write per cycle while pop does not
// stall the output; a request needs 1 to 6 writes (2 for a mode set).
// A two-entry job queue lets requests be accepted while writes go out.
// When pop stays low the output register holds, the write stage stops, the
// job queue fills and full rises.
// Reset: page addressing mode, page 0, column 0, width 128, address 60; job
// queue and output register empty.
module oled_page_write_command_sequencer_unit #(
  parameter int unsigned MaxColumns = opwcs_pkg::MaxColumnsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  opwcs_pkg::req_t      req_i,
  output logic                 empty,
  input  logic                 pop,
  output opwcs_pkg::rsp_t      rsp_o,
  input  logic                 cfg_we_i,
  input  opwcs_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);
  import opwcs_pkg::*;

  logic [7:0]   panel_width_q;
  logic [6:0]   dev_addr_q;
  logic         job_push;
  logic         job_pop;
  job_t         job_in;
  job_t         job_out;
  jobq_status_t jobq_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q <= PanelWidthRst;
      dev_addr_q    <= DevAddrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PANEL_WIDTH:    panel_width_q <= cfg_wdata_i;
        CFG_DEVICE_ADDRESS: dev_addr_q    <= cfg_wdata_i[6:0];
        default:            ;
      endcase
    end
  end

  opwcs_front #(
    .MaxColumns(MaxColumns)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .req_i        (req_i),
    .panel_width_i(panel_width_q),
    .jobq_status_i(jobq_status),
    .full_o       (full),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  opwcs_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .status_o(jobq_status)
  );

  opwcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .jobq_status_i(jobq_status),
    .dev_addr_i   (dev_addr_q),
    .pop_i        (pop),
    .job_pop_o    (job_pop),
    .empty_o      (empty),
    .rsp_o        (rsp_o)
  );

endmodule
